// ----- sv/sfr_pkg.sv -----
// Shared types and constants for the S.BUS frame receiver.
package sfr_pkg;

	localparam int CHANNEL_COUNT = 16;
	localparam int FRAME_LENGTH  = 25;
	localparam int CHAN_W        = 11;
	localparam int CHAN_IDX_W    = 4;
	localparam int PAYLOAD_BYTES = 22;
	localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
	localparam int POS_W         = 5;
	localparam int SILENCE_W     = 17;
	localparam int AGE_W         = 21;
	localparam int GAP_W         = 16;
	localparam int TIMEOUT_W     = 20;
	localparam int BAD_W         = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 20;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = 1;
	localparam int QCNT_W        = 2;

	localparam logic [7:0] START_BYTE   = 8'h0F;
	localparam int         FAILSAFE_POS = 3;

	localparam logic [POS_W-1:0] POS_FIRST_PAYLOAD = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LAST_PAYLOAD  = POS_W'(PAYLOAD_BYTES);
	localparam logic [POS_W-1:0] POS_FLAGS         = POS_W'(PAYLOAD_BYTES + 1);
	localparam logic [POS_W-1:0] POS_END           = POS_W'(FRAME_LENGTH - 1);
	localparam logic [POS_W-1:0] POS_LIMIT         = POS_W'(FRAME_LENGTH);

	localparam logic [GAP_W-1:0]     GAP_RESET     = GAP_W'(1000);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100000);

	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT = CFG_IDX_W'(1);

	localparam logic CMD_BYTE = 1'b0;

	// One queue entry: what the back end has to emit for one input beat.
	typedef struct packed {
		logic                 good;
		logic                 failsafe;
		logic                 connected;
		logic [BAD_W-1:0]     bad_count;
		logic [PAYLOAD_W-1:0] payload;
	} cmd_t;

endpackage

// ----- sv/sfr_front.sv -----
// Front end: byte/tick decode, frame assembly, counters and status.
module sfr_front import sfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic                  command,
	input  logic [7:0]            rx_byte,
	output cmd_t                  cmd
);

	logic [GAP_W-1:0]     gap_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [POS_W-1:0]     pos_q, pos_d, pos0;
	logic [SILENCE_W-1:0] silence_q, silence_d;
	logic [AGE_W-1:0]     age_q, age_d;
	logic                 fs_q, fs_d;
	logic                 fs_bit_q;
	logic [BAD_W-1:0]     bad_q, bad_d;
	logic [PAYLOAD_W-1:0] payload_q;
	logic                 in_frame, good;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q     <= GAP_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GAP_LIMIT:    gap_q     <= cfg_data[GAP_W-1:0];
				REG_LINK_TIMEOUT: timeout_q <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pos_d     = pos_q;
		silence_d = silence_q;
		age_d     = age_q;
		fs_d      = fs_q;
		bad_d     = bad_q;
		good      = 1'b0;
		pos0      = pos_q;
		in_frame  = 1'b0;
		if (command != CMD_BYTE) begin
			if (silence_q != '1) silence_d = silence_q + SILENCE_W'(1);
			if (age_q != '1)     age_d     = age_q + AGE_W'(1);
		end else begin
			silence_d = '0;
			if (silence_q > SILENCE_W'(gap_q)) pos0 = '0;
			if (pos0 >= POS_LIMIT)             pos0 = '0;
			in_frame = (pos0 != '0) || (rx_byte == START_BYTE);
			pos_d    = pos0;
			if (in_frame) begin
				if (pos0 < POS_END) begin
					pos_d = pos0 + POS_W'(1);
				end else begin
					pos_d = '0;
					if (rx_byte == 8'h00) begin
						good  = 1'b1;
						fs_d  = fs_bit_q;
						age_d = '0;
					end else begin
						bad_d = bad_q + BAD_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			silence_q <= '0;
			age_q     <= '0;
			fs_q      <= 1'b1;
			bad_q     <= '0;
		end else if (accept) begin
			pos_q     <= pos_d;
			silence_q <= silence_d;
			age_q     <= age_d;
			fs_q      <= fs_d;
			bad_q     <= bad_d;
		end
	end

	// Payload bytes shift in from the top, so byte 1 ends at the bottom.
	always_ff @(posedge clk) begin
		if (accept && command == CMD_BYTE && in_frame) begin
			if (pos0 >= POS_FIRST_PAYLOAD && pos0 <= POS_LAST_PAYLOAD)
				payload_q <= {rx_byte, payload_q[PAYLOAD_W-1:8]};
			if (pos0 == POS_FLAGS)
				fs_bit_q <= rx_byte[FAILSAFE_POS];
		end
	end

	always_comb begin
		cmd.good      = good;
		cmd.failsafe  = fs_d;
		cmd.connected = !fs_d && (age_d <= AGE_W'(timeout_q));
		cmd.bad_count = bad_d;
		cmd.payload   = payload_q;
	end

endmodule

// ----- sv/sfr_queue.sv -----
// Two-entry queue between the front and back ends.
module sfr_queue import sfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

// ----- sv/sfr_back.sv -----
// Back end: queue entries to output beats, one channel per good beat.
module sfr_back import sfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  cmd_t                  head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  channel_valid,
	output logic [CHAN_IDX_W-1:0] channel_index,
	output logic [CHAN_W-1:0]     channel_value,
	output logic                  failsafe_flag,
	output logic                  radio_connected,
	output logic [BAD_W-1:0]      bad_frame_count,
	output logic                  last_of_run
);

	logic                  active_q;
	logic                  good_q;
	logic                  fs_q, conn_q;
	logic [BAD_W-1:0]      bad_q;
	logic [CHAN_IDX_W-1:0] idx_q;
	logic [PAYLOAD_W-1:0]  shift_q;
	logic                  last, done;

	assign last = !good_q || (idx_q == CHAN_IDX_W'(CHANNEL_COUNT - 1));
	assign done = out_ready && last;
	assign pop  = !empty && (!active_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (pop) begin
			active_q <= 1'b1;
		end else if (done) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			good_q  <= head.good;
			fs_q    <= head.failsafe;
			conn_q  <= head.connected;
			bad_q   <= head.bad_count;
			shift_q <= head.payload;
			idx_q   <= '0;
		end else if (active_q && out_ready && !last) begin
			shift_q <= {CHAN_W'(0), shift_q[PAYLOAD_W-1:CHAN_W]};
			idx_q   <= idx_q + CHAN_IDX_W'(1);
		end
	end

	assign out_valid       = active_q;
	assign channel_valid   = good_q;
	assign channel_index   = good_q ? idx_q : '0;
	assign channel_value   = good_q ? shift_q[CHAN_W-1:0] : '0;
	assign failsafe_flag   = fs_q;
	assign radio_connected = conn_q;
	assign bad_frame_count = bad_q;
	assign last_of_run     = last;

endmodule

// ----- sv/sbus_frame_receiver.sv -----
// Top level of the S.BUS frame receiver: front end, queue and back end.
//
// Input channel (in_valid/in_ready): each beat is either a received UART
// byte (command 0, rx_byte) or a one-microsecond tick (command 1).
// Output channel (out_valid/out_ready): a good frame gives sixteen beats,
// channels 0..15, with last_of_run on the sixteenth; every other input
// beat gives one status beat with the channel fields at zero.
// Status fields (failsafe, link, bad-frame count) are those after the input.
// Configuration: cfg_write with cfg_index 0 (gap limit) or 1 (link timeout)
// and cfg_data; write only while the block is idle.
// Path: each entry is registered in the queue, then in the back end.
// Throughput: one input beat per cycle while the two-entry queue has room;
// the back end emits one beat per cycle while out_ready is high, so a good
// frame holds it for sixteen beats and the queue fills behind it. In_ready
// drops only when the queue is full, so a stalled receiver backs up into
// the input side after two more beats.
// Reset: frame position, silence and link-age counters and bad-frame count
// clear, failsafe is set, registers return to 1000 and 100000 ticks.
module sbus_frame_receiver import sfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  channel_valid,
	output logic [CHAN_IDX_W-1:0] channel_index,
	output logic [CHAN_W-1:0]     channel_value,
	output logic                  failsafe_flag,
	output logic                  radio_connected,
	output logic [BAD_W-1:0]      bad_frame_count,
	output logic                  last_of_run
);

	cmd_t front_cmd, q_head;
	logic q_full, q_empty, q_pop, accept;

	// an input beat is taken whenever the queue can hold its entry
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	sfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.command   (command),
		.rx_byte   (rx_byte),
		.cmd       (front_cmd)
	);

	sfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	sfr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.empty           (q_empty),
		.head            (q_head),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.channel_valid   (channel_valid),
		.channel_index   (channel_index),
		.channel_value   (channel_value),
		.failsafe_flag   (failsafe_flag),
		.radio_connected (radio_connected),
		.bad_frame_count (bad_frame_count),
		.last_of_run     (last_of_run)
	);

endmodule
